// ===== rtl/plc_pkg.sv =====
// ----------------------------------------------------------------------------
// plc_pkg
// shared types and codes for the positional list block
// ----------------------------------------------------------------------------
package plc_pkg;

  // largest supported list depth, sets the width of shift positions
  localparam int MAX_DEPTH   = 4096;
  localparam int SHIFT_W     = $clog2(MAX_DEPTH);
  localparam int DEF_DEPTH   = 64;

  // item field widths
  localparam int FUNC_W      = 3;
  localparam int POS_W       = 6;
  localparam int DATA_W      = 32;
  localparam int ECOUNT_W    = 7;
  localparam int STATUS_W    = 2;

  typedef enum logic [FUNC_W-1:0] {
    FN_APPEND    = 3'd0,
    FN_PREPEND   = 3'd1,
    FN_INSERT    = 3'd2,
    FN_POP_LAST  = 3'd3,
    FN_POP_FIRST = 3'd4,
    FN_ERASE     = 3'd5,
    FN_READ      = 3'd6
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_BADPOS = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    SH_HOLD,
    SH_INSERT,
    SH_REMOVE
  } shift_op_t;

  // command broadcast to every cell of the chain
  typedef struct packed {
    shift_op_t          op;
    logic [SHIFT_W-1:0] at;
  } shift_cmd_t;

endpackage

// ===== rtl/plc_in_if.sv =====
// ----------------------------------------------------------------------------
// plc_in_if
// request channel: one list operation per item
// ----------------------------------------------------------------------------
interface plc_in_if;
  logic                                valid;
  logic                                ready;
  logic [plc_pkg::FUNC_W-1:0]          func;
  logic [plc_pkg::POS_W-1:0]           position;
  logic signed [plc_pkg::DATA_W-1:0]   value;

  modport source (output valid, output func, output position, output value, input ready);
  modport sink   (input valid, input func, input position, input value, output ready);
endinterface

// ===== rtl/plc_out_if.sv =====
// ----------------------------------------------------------------------------
// plc_out_if
// result channel: one item per accepted request
// ----------------------------------------------------------------------------
interface plc_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [plc_pkg::DATA_W-1:0]   read_value;
  logic [plc_pkg::ECOUNT_W-1:0]        entry_count;
  logic [plc_pkg::STATUS_W-1:0]        status;

  modport source (output valid, output read_value, output entry_count, output status,
                  input ready);
  modport sink   (input valid, input read_value, input entry_count, input status,
                  output ready);
endinterface

// ===== rtl/positional_list_insert_erase.sv =====
// ----------------------------------------------------------------------------
// positional_list_insert_erase
// ordered list of signed 32-bit values in a row of shifting cells
// ----------------------------------------------------------------------------
//
// channel    dir   handshake      payload
// item_in    in    valid/ready    func, position, value
// item_out   out   valid/ready    read_value, entry_count, status
//
// every cell loads from its neighbor in the same cycle, so an insert or removal
// anywhere in the list is done in the one update made when the item is taken
// the result lands in an output register; a new item is taken whenever that
// register is empty or being drained in the same cycle
// a stall on item_out holds item_in off once the output register is full
// synchronous reset clears the entry count and the output valid; the cell
// contents are left as they are and only entries below the count are read
// ----------------------------------------------------------------------------
module positional_list_insert_erase #(
  parameter int DEPTH = plc_pkg::DEF_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  plc_in_if.sink          item_in,
  plc_out_if.source       item_out
);

  localparam int CW   = $clog2(DEPTH+1);
  // position can only name the first 64 entries
  localparam int RD_N = (DEPTH < (1 << plc_pkg::POS_W)) ? DEPTH : (1 << plc_pkg::POS_W);

  // entry count and handshake
  logic [CW-1:0]        count;
  logic [CW-1:0]        count_next;
  logic                 accept;

  // decoded operation
  plc_pkg::shift_cmd_t  dec_cmd;
  plc_pkg::shift_cmd_t  cell_cmd;
  plc_pkg::status_t     dec_status;
  logic                 read_ok;

  // cell chain and read selection
  logic signed [plc_pkg::DATA_W-1:0] cell_q [DEPTH];
  logic signed [plc_pkg::DATA_W-1:0] read_sel;

  assign item_in.ready = !item_out.valid || item_out.ready;
  assign accept        = item_in.valid && item_in.ready;

  plc_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .func       (item_in.func),
    .position   (item_in.position),
    .count      (count),
    .cmd        (dec_cmd),
    .count_next (count_next),
    .status     (dec_status),
    .read_ok    (read_ok)
  );

  // cells only move on an accepted item
  always_comb begin
    cell_cmd = dec_cmd;
    if (!accept) begin
      cell_cmd.op = plc_pkg::SH_HOLD;
    end
  end

  // row of cells: entry i sits in cell i, neighbors feed each other
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [plc_pkg::DATA_W-1:0] left_d;
    logic signed [plc_pkg::DATA_W-1:0] right_d;

    if (i == 0) begin : g_head
      assign left_d = item_in.value;
    end else begin : g_left
      assign left_d = cell_q[i-1];
    end

    if (i == DEPTH-1) begin : g_tail
      assign right_d = '0;
    end else begin : g_right
      assign right_d = cell_q[i+1];
    end

    plc_cell #(
      .INDEX (i)
    ) u_cell (
      .clk     (clk),
      .cmd     (cell_cmd),
      .value   (item_in.value),
      .left_q  (left_d),
      .right_q (right_d),
      .q       (cell_q[i])
    );
  end

  // and-or select over the addressable cells
  always_comb begin
    read_sel = '0;
    for (int i = 0; i < RD_N; i++) begin
      if (item_in.position == plc_pkg::POS_W'(i)) begin
        read_sel = read_sel | cell_q[i];
      end
    end
  end

  // entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (accept) begin
      count <= count_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_out.valid <= 1'b0;
    end else if (accept) begin
      item_out.valid <= 1'b1;
    end else if (item_out.ready) begin
      item_out.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_out.read_value  <= read_ok ? read_sel : '0;
      item_out.entry_count <= plc_pkg::ECOUNT_W'(count_next);
      item_out.status      <= dec_status;
    end
  end

  // count stays within the store
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("entry count beyond depth");

  // count only moves when an item is taken
  a_count_idle: assert property (@(posedge clk) disable iff (rst)
    !accept |=> count == $past(count))
    else $error("entry count changed without an item");

  // a full or empty refusal leaves the count unchanged
  a_refuse_hold: assert property (@(posedge clk) disable iff (rst)
    accept && (dec_status == plc_pkg::ST_FULL || dec_status == plc_pkg::ST_EMPTY)
      |=> count == $past(count))
    else $error("refused operation changed the count");

  // a taken item always shows up as a result next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> item_out.valid)
    else $error("accepted item produced no result");

endmodule

// ===== rtl/plc_cell.sv =====
// ----------------------------------------------------------------------------
// plc_cell
// one list entry; takes the new value at its index on an insert, else loads from its left or right neighbor on a shift
// ----------------------------------------------------------------------------
module plc_cell #(
  parameter int INDEX = 0
) (
  input  logic                              clk,
  input  plc_pkg::shift_cmd_t               cmd,
  input  logic signed [plc_pkg::DATA_W-1:0] value,
  input  logic signed [plc_pkg::DATA_W-1:0] left_q,
  input  logic signed [plc_pkg::DATA_W-1:0] right_q,
  output logic signed [plc_pkg::DATA_W-1:0] q
);

  localparam logic [plc_pkg::SHIFT_W-1:0] Idx = plc_pkg::SHIFT_W'(INDEX);

  logic signed [plc_pkg::DATA_W-1:0] q_next;

  always_comb begin
    q_next = q;
    case (cmd.op)
      plc_pkg::SH_INSERT: begin
        if (Idx > cmd.at) begin
          q_next = left_q;
        end else if (Idx == cmd.at) begin
          q_next = value;
        end
      end
      plc_pkg::SH_REMOVE: begin
        if (Idx >= cmd.at) begin
          q_next = right_q;
        end
      end
      default: q_next = q;
    endcase
  end

  // payload only, no reset
  always_ff @(posedge clk) begin
    q <= q_next;
  end

endmodule

// ===== rtl/plc_ctrl.sv =====
// ----------------------------------------------------------------------------
// plc_ctrl
// decodes one operation against the entry count: status, read enable, new count, shift
// ----------------------------------------------------------------------------
module plc_ctrl #(
  parameter int DEPTH = plc_pkg::DEF_DEPTH
) (
  input  logic [plc_pkg::FUNC_W-1:0]   func,
  input  logic [plc_pkg::POS_W-1:0]    position,
  input  logic [$clog2(DEPTH+1)-1:0]   count,
  output plc_pkg::shift_cmd_t          cmd,
  output logic [$clog2(DEPTH+1)-1:0]   count_next,
  output plc_pkg::status_t             status,
  output logic                         read_ok
);

  localparam int CW = $clog2(DEPTH+1);
  localparam int XW = (CW > plc_pkg::POS_W) ? CW : plc_pkg::POS_W;

  logic          full;
  logic          empty;
  logic [XW-1:0] pos_x;
  logic [XW-1:0] cnt_x;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign pos_x = XW'(position);
  assign cnt_x = XW'(count);

  always_comb begin
    cmd.op     = plc_pkg::SH_HOLD;
    cmd.at     = '0;
    count_next = count;
    status     = plc_pkg::ST_OK;
    read_ok    = 1'b0;
    case (plc_pkg::func_t'(func))
      plc_pkg::FN_APPEND: begin
        if (full) begin
          status = plc_pkg::ST_FULL;
        end else begin
          cmd.op     = plc_pkg::SH_INSERT;
          cmd.at     = plc_pkg::SHIFT_W'(count);
          count_next = count + CW'(1);
        end
      end
      plc_pkg::FN_PREPEND: begin
        if (full) begin
          status = plc_pkg::ST_FULL;
        end else begin
          cmd.op     = plc_pkg::SH_INSERT;
          count_next = count + CW'(1);
        end
      end
      plc_pkg::FN_INSERT: begin
        if (full) begin
          status = plc_pkg::ST_FULL;
        end else if (pos_x > cnt_x) begin
          status = plc_pkg::ST_BADPOS;
        end else begin
          cmd.op     = plc_pkg::SH_INSERT;
          cmd.at     = plc_pkg::SHIFT_W'(position);
          count_next = count + CW'(1);
        end
      end
      plc_pkg::FN_POP_LAST: begin
        if (empty) begin
          status = plc_pkg::ST_EMPTY;
        end else begin
          count_next = count - CW'(1);
        end
      end
      plc_pkg::FN_POP_FIRST: begin
        if (empty) begin
          status = plc_pkg::ST_EMPTY;
        end else begin
          cmd.op     = plc_pkg::SH_REMOVE;
          count_next = count - CW'(1);
        end
      end
      plc_pkg::FN_ERASE: begin
        if (empty) begin
          status = plc_pkg::ST_EMPTY;
        end else if (pos_x >= cnt_x) begin
          status = plc_pkg::ST_BADPOS;
        end else begin
          cmd.op     = plc_pkg::SH_REMOVE;
          cmd.at     = plc_pkg::SHIFT_W'(position);
          count_next = count - CW'(1);
        end
      end
      plc_pkg::FN_READ: begin
        if (pos_x >= cnt_x) begin
          status = plc_pkg::ST_BADPOS;
        end else begin
          read_ok = 1'b1;
        end
      end
      default: begin
        // unused code: no change, status ok
        status = plc_pkg::ST_OK;
      end
    endcase
  end

endmodule
